// ===== rtl/typed_record_serializer_assert.svh =====
`ifndef TYPED_RECORD_SERIALIZER_ASSERT_SVH
`define TYPED_RECORD_SERIALIZER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("typed_record_serializer: check failed");

// Check cons in the cycle after ante.
`define TRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("typed_record_serializer: check failed");

`endif

// ===== rtl/trs_pkg.sv =====
package trs_pkg;

   localparam int REQ_DATA_W = 152;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;
   localparam int CODE_DEPTH = 256;
   localparam int CODE_W     = 4;

   localparam logic [2:0] CMD_NULL  = 3'd0;
   localparam logic [2:0] CMD_INT   = 3'd1;
   localparam logic [2:0] CMD_FLOAT = 3'd2;
   localparam logic [2:0] CMD_TEXT  = 3'd3;
   localparam logic [2:0] CMD_BLOB  = 3'd4;
   localparam logic [2:0] CMD_BYTE  = 3'd5;

   localparam logic [3:0] CODE_NULL  = 4'd1;
   localparam logic [3:0] CODE_ZERO  = 4'd2;
   localparam logic [3:0] CODE_ONE   = 4'd3;
   localparam logic [3:0] CODE_INT8  = 4'd4;
   localparam logic [3:0] CODE_INT16 = 4'd5;
   localparam logic [3:0] CODE_INT32 = 4'd6;
   localparam logic [3:0] CODE_INT64 = 4'd7;
   localparam logic [3:0] CODE_FLOAT = 4'd8;
   localparam logic [3:0] CODE_TEXT  = 4'd9;
   localparam logic [3:0] CODE_BLOB  = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic signed [63:0] INT8_MIN  = -64'sd128;
   localparam logic signed [63:0] INT8_MAX  = 64'sd127;
   localparam logic signed [63:0] INT16_MIN = -64'sd32768;
   localparam logic signed [63:0] INT16_MAX = 64'sd32767;
   localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WRITE = 3'b010,
      S_READ  = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      SRC_REG     = 2'd0,
      SRC_CODE    = 2'd1,
      SRC_PAYLOAD = 2'd2
   } src_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [3:0]  nbytes;
      logic [63:0] word;
   } int_info_type;

   // word holds the payload bytes left-aligned, first byte out on top
   function automatic int_info_type classify_int(input logic signed [63:0] value);
      int_info_type info;
      info.code   = CODE_INT64;
      info.nbytes = 4'd8;
      info.word   = value;
      if (value == 64'sd0) begin
         info.code   = CODE_ZERO;
         info.nbytes = 4'd0;
      end else if (value == 64'sd1) begin
         info.code   = CODE_ONE;
         info.nbytes = 4'd0;
      end else if (value >= INT8_MIN && value <= INT8_MAX) begin
         info.code   = CODE_INT8;
         info.nbytes = 4'd1;
         info.word   = {value[7:0], 56'd0};
      end else if (value >= INT16_MIN && value <= INT16_MAX) begin
         info.code   = CODE_INT16;
         info.nbytes = 4'd2;
         info.word   = {value[15:0], 48'd0};
      end else if (value >= INT32_MIN && value <= INT32_MAX) begin
         info.code   = CODE_INT32;
         info.nbytes = 4'd4;
         info.word   = {value[31:0], 32'd0};
      end
      return info;
   endfunction

   function automatic logic [63:0] byte_swap(input logic [63:0] bits);
      logic [63:0] swapped;
      for (int k = 0; k < 8; k++) begin
         swapped[8*k +: 8] = bits[56-8*k +: 8];
      end
      return swapped;
   endfunction

endpackage

// ===== rtl/trs_ram.sv =====
module trs_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/typed_record_serializer.sv =====
// Typed record serializer.
// req channel: an item either appends a field (req_tuser[3] low; command in
// req_tuser[2:0]) or asks for the next record byte (req_tuser[3] high).
// rsp channel: one item per read: record byte in rsp_tdata, rsp_tlast on the
// final byte (the record then clears), status in rsp_tuser.
// A null field, a content byte, a dropped field or a reserved command is
// taken without leaving the idle state. Integer, float, text and blob starts
// write n payload bytes (0 to 8) after the accept, one a cycle through the
// single write port of the payload memory. A read goes through the memory
// read, then the load of the output register, which waits until it is free.
// Reset clears the field count, lengths, read position and error flags; the
// memories keep their contents and are not cleared.
// When rsp_tready is low the output register holds its item; appends are
// still taken, and a further read waits until the output register drains.
module typed_record_serializer #(
   parameter int PAYLOAD_DEPTH = 4096,
   parameter int MAX_FIELDS    = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // int_value[63:0], float_bits[127:64], content_length[140:128],
   // content_byte[148:141], zero fill
   input  logic [trs_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[2:0], read_request[3]
   input  logic [trs_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_byte[7:0]
   output logic [trs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // status[1:0]
   output logic [trs_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam int AW  = $clog2(PAYLOAD_DEPTH);
   localparam int PLW = $clog2(PAYLOAD_DEPTH + 1);
   localparam int RPW = $clog2(PAYLOAD_DEPTH + 256);
   localparam int SW  = ((PLW > 14) ? PLW : 14) + 1;
   localparam int CAW = $clog2(trs_pkg::CODE_DEPTH);

   trs_pkg::state_type state_ff, state_in;
   logic [7:0]          field_count_ff, field_count_in;
   logic [PLW-1:0]      payload_length_ff, payload_length_in;
   logic [RPW-1:0]      read_position_ff, read_position_in;
   logic [PLW-1:0]      content_remaining_ff, content_remaining_in;
   logic [1:0]          error_flags_ff, error_flags_in;
   logic [63:0]         shift_ff, shift_in;
   logic [3:0]          count_ff, count_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   trs_pkg::src_type    src_ff, src_in;
   logic [7:0]          reg_byte_ff, reg_byte_in;
   logic                last_ff, last_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [2:0]            command;
   logic                  read_request;
   logic signed [63:0]    int_value;
   logic [63:0]           float_bits;
   logic [12:0]           content_length;
   logic [7:0]            content_byte;
   trs_pkg::int_info_type int_info;

   logic [SW-1:0]       need;
   logic [3:0]          new_code;
   logic [63:0]         new_word;
   logic [3:0]          new_count;
   logic [RPW-1:0]      pay_index;
   logic [PLW-1:0]      fill_index;

   logic                code_we;
   logic [CAW-1:0]      code_waddr;
   logic                code_re;
   logic [CAW-1:0]      code_raddr;
   logic [3:0]          code_rdata;
   logic                pay_we;
   logic [AW-1:0]       pay_waddr;
   logic [7:0]          pay_wdata;
   logic                pay_re;
   logic [AW-1:0]       pay_raddr;
   logic [7:0]          pay_rdata;
   logic                out_free;

   assign accept         = req_tvalid && req_tready;
   assign command        = req_tuser[2:0];
   assign read_request   = req_tuser[3];
   assign int_value      = signed'(req_tdata[63:0]);
   assign float_bits     = req_tdata[127:64];
   assign content_length = req_tdata[140:128];
   assign content_byte   = req_tdata[148:141];
   assign int_info       = trs_pkg::classify_int(int_value);
   assign req_tready     = (state_ff == trs_pkg::S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign pay_index      = read_position_ff - RPW'(1) - RPW'(field_count_ff);
   assign fill_index     = payload_length_ff - content_remaining_ff;

   always_comb begin
      new_code  = trs_pkg::CODE_NULL;
      new_word  = 64'd0;
      new_count = 4'd0;
      need      = '0;
      case (command)
         trs_pkg::CMD_INT: begin
            new_code  = int_info.code;
            new_word  = int_info.word;
            new_count = int_info.nbytes;
            need      = SW'(int_info.nbytes);
         end
         trs_pkg::CMD_FLOAT: begin
            new_code  = trs_pkg::CODE_FLOAT;
            new_word  = trs_pkg::byte_swap(float_bits);
            new_count = 4'd8;
            need      = SW'(8);
         end
         trs_pkg::CMD_TEXT, trs_pkg::CMD_BLOB: begin
            new_code  = (command == trs_pkg::CMD_TEXT) ? trs_pkg::CODE_TEXT
                                                       : trs_pkg::CODE_BLOB;
            new_word  = {19'd0, content_length, 32'd0};
            new_count = 4'd4;
            need      = SW'(content_length) + SW'(4);
         end
         default: begin
            new_code = trs_pkg::CODE_NULL;
         end
      endcase
   end

   always_comb begin
      state_in             = state_ff;
      field_count_in       = field_count_ff;
      payload_length_in    = payload_length_ff;
      read_position_in     = read_position_ff;
      content_remaining_in = content_remaining_ff;
      error_flags_in       = error_flags_ff;
      shift_in             = shift_ff;
      count_in             = count_ff;
      wr_addr_in           = wr_addr_ff;
      src_in               = src_ff;
      reg_byte_in          = reg_byte_ff;
      last_in              = last_ff;
      status_in            = status_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_tready;
      rsp_byte_in          = rsp_byte_ff;
      rsp_last_in          = rsp_last_ff;
      rsp_status_in        = rsp_status_ff;
      code_we              = 1'b0;
      code_waddr           = field_count_ff;
      code_re              = 1'b0;
      code_raddr           = CAW'(read_position_ff - RPW'(1));
      pay_we               = 1'b0;
      pay_waddr            = wr_addr_ff;
      pay_wdata            = shift_ff[63:56];
      pay_re               = 1'b0;
      pay_raddr            = pay_index[AW-1:0];

      case (state_ff)
         trs_pkg::S_IDLE: begin
            if (accept && read_request) begin
               state_in = trs_pkg::S_READ;
               if (field_count_ff == 8'd0) begin
                  src_in      = trs_pkg::SRC_REG;
                  reg_byte_in = 8'd0;
                  last_in     = 1'b1;
                  status_in   = trs_pkg::ST_EMPTY;
               end else begin
                  if (error_flags_ff[1]) begin
                     status_in = trs_pkg::ST_OVERFLOW;
                  end else if (error_flags_ff[0]) begin
                     status_in = trs_pkg::ST_DROPPED;
                  end else begin
                     status_in = trs_pkg::ST_OK;
                  end
                  last_in = (read_position_ff >=
                             RPW'(field_count_ff) + RPW'(payload_length_ff));
                  reg_byte_in = field_count_ff;
                  if (read_position_ff == '0) begin
                     src_in = trs_pkg::SRC_REG;
                  end else if (read_position_ff <= RPW'(field_count_ff)) begin
                     src_in  = trs_pkg::SRC_CODE;
                     code_re = 1'b1;
                  end else begin
                     src_in = trs_pkg::SRC_PAYLOAD;
                     pay_re = 1'b1;
                  end
                  read_position_in = read_position_ff + RPW'(1);
               end
               if (last_in) begin
                  field_count_in       = 8'd0;
                  payload_length_in    = '0;
                  read_position_in     = '0;
                  content_remaining_in = '0;
                  error_flags_in       = 2'b00;
               end
            end else if (accept && command == trs_pkg::CMD_BYTE) begin
               if (content_remaining_ff != '0) begin
                  pay_we               = 1'b1;
                  pay_waddr            = fill_index[AW-1:0];
                  pay_wdata            = content_byte;
                  content_remaining_in = content_remaining_ff - PLW'(1);
               end
            end else if (accept && command inside {trs_pkg::CMD_NULL, trs_pkg::CMD_INT,
                                                  trs_pkg::CMD_FLOAT, trs_pkg::CMD_TEXT,
                                                  trs_pkg::CMD_BLOB}) begin
               content_remaining_in = '0;
               if (field_count_ff >= 8'(MAX_FIELDS)) begin
                  error_flags_in = error_flags_ff | 2'b01;
               end else if (SW'(payload_length_ff) + need > SW'(PAYLOAD_DEPTH)) begin
                  error_flags_in = error_flags_ff | 2'b10;
               end else begin
                  code_we           = 1'b1;
                  field_count_in    = field_count_ff + 8'd1;
                  payload_length_in = PLW'(SW'(payload_length_ff) + need);
                  shift_in          = new_word;
                  count_in          = new_count;
                  wr_addr_in        = payload_length_ff[AW-1:0];
                  if (command == trs_pkg::CMD_TEXT || command == trs_pkg::CMD_BLOB) begin
                     content_remaining_in = PLW'(content_length);
                  end
                  if (new_count != 4'd0) begin
                     state_in = trs_pkg::S_WRITE;
                  end
               end
            end
         end
         trs_pkg::S_WRITE: begin
            pay_we     = 1'b1;
            shift_in   = {shift_ff[55:0], 8'd0};
            wr_addr_in = wr_addr_ff + AW'(1);
            count_in   = count_ff - 4'd1;
            if (count_ff == 4'd1) begin
               state_in = trs_pkg::S_IDLE;
            end
         end
         trs_pkg::S_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = last_ff;
               rsp_status_in = status_ff;
               case (src_ff)
                  trs_pkg::SRC_CODE:    rsp_byte_in = {4'd0, code_rdata};
                  trs_pkg::SRC_PAYLOAD: rsp_byte_in = pay_rdata;
                  default:              rsp_byte_in = reg_byte_ff;
               endcase
               state_in = trs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = trs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= trs_pkg::S_IDLE;
         field_count_ff       <= 8'd0;
         payload_length_ff    <= '0;
         read_position_ff     <= '0;
         content_remaining_ff <= '0;
         error_flags_ff       <= 2'b00;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         field_count_ff       <= field_count_in;
         payload_length_ff    <= payload_length_in;
         read_position_ff     <= read_position_in;
         content_remaining_ff <= content_remaining_in;
         error_flags_ff       <= error_flags_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      count_ff      <= count_in;
      wr_addr_ff    <= wr_addr_in;
      src_ff        <= src_in;
      reg_byte_ff   <= reg_byte_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   trs_ram #(
      .DEPTH (trs_pkg::CODE_DEPTH),
      .WIDTH (trs_pkg::CODE_W)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (code_waddr),
      .wr_data (new_code),
      .rd_en   (code_re),
      .rd_addr (code_raddr),
      .rd_data (code_rdata)
   );

   trs_ram #(
      .DEPTH (PAYLOAD_DEPTH),
      .WIDTH (8)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (pay_wdata),
      .rd_en   (pay_re),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/trs_checker.sv =====
`include "typed_record_serializer_assert.svh"

module trs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [trs_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [trs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic [trs_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic                                                read_accept;
   logic                                                empty_rsp;
   logic [trs_pkg::RSP_DATA_W+trs_pkg::RSP_USER_W:0]    rsp_item;

   assign read_accept = req_tvalid && req_tready && req_tuser[3];
   assign empty_rsp   = rsp_tvalid && (rsp_tuser == trs_pkg::ST_EMPTY);
   assign rsp_item    = {rsp_tdata, rsp_tlast, rsp_tuser};

   // hold a stalled result
   `TRS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_item))

   // a fresh result follows its read item through the memory read and the output register
   `TRS_ASSERT_NOW(a_rsp_from_read, $rose(rsp_tvalid), $past(read_accept, 2))

   // stall input while a read is in flight
   `TRS_ASSERT_NEXT(a_read_blocks_req, read_accept, !req_tready)

   // empty record answers a zero last byte
   `TRS_ASSERT_NOW(a_empty_is_last, empty_rsp, rsp_tlast && rsp_tdata == 8'd0)

endmodule

bind typed_record_serializer trs_checker u_trs_checker (.*);

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAYLOAD_DEPTH = 4096;
   localparam int MAX_FIELDS    = 255;
   localparam int QUIET_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 250;
   localparam int CALM_START    = 500;
   localparam int CALM_END      = 800;

   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } rec_byte_type;

   typedef struct packed {
      logic [2:0]   cmd;
      logic [63:0]  ival;
      logic [63:0]  fbits;
      logic [12:0]  clen;
      logic [7:0]   cbyte;
      logic         rd;
      logic         has_rsp;
      rec_byte_type want;
   } field_req_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [trs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [trs_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [trs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic [trs_pkg::RSP_USER_W-1:0] rsp_tuser;

   // record image built up from the queued items
   logic [7:0]  rec_fields = '0;
   logic [3:0]  code_mem [trs_pkg::CODE_DEPTH];
   logic [7:0]  byte_mem [PAYLOAD_DEPTH];
   bit          byte_set [PAYLOAD_DEPTH];
   logic [12:0] rec_len = '0;
   logic [12:0] rd_pos = '0;
   logic [12:0] owed = '0;
   logic [1:0]  err_bits = '0;

   field_req_type pending_reqs [$];
   rec_byte_type  expected_bytes [$];
   field_req_type on_bus;
   rec_byte_type  head_byte;
   int            stim_count = 0;
   int            mismatches = 0;
   int            cycle_no = 0;
   int            quiet_cycles = 0;
   int            checked_bytes = 0;
   int            hold_left = 0;
   bit            held = 1'b0;

   typed_record_serializer #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
      .MAX_FIELDS(MAX_FIELDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   function automatic bit idle_roll();
      return (cycle_no < CALM_START || cycle_no >= CALM_END) && ($urandom_range(99) < 37);
   endfunction

   function automatic void wipe_record();
      rec_fields = '0;
      rec_len    = '0;
      rd_pos     = '0;
      owed       = '0;
      err_bits   = '0;
   endfunction

   function automatic bit has_room(input int need);
      if (rec_fields >= MAX_FIELDS) begin
         err_bits[0] = 1'b1;
         return 1'b0;
      end
      if (int'(rec_len) + need > PAYLOAD_DEPTH) begin
         err_bits[1] = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_code(input logic [3:0] code);
      code_mem[rec_fields] = code;
      rec_fields = rec_fields + 8'd1;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      byte_mem[rec_len] = b;
      byte_set[rec_len] = 1'b1;
      rec_len = rec_len + 13'd1;
   endfunction

   function automatic field_req_type serialize_step(input field_req_type it);
      int          total;
      int          pos;
      int          nb;
      logic [63:0] v;
      logic [3:0]  code;
      it.has_rsp = 1'b0;
      it.want = '0;
      if (it.rd) begin
         it.has_rsp = 1'b1;
         if (rec_fields == 0) begin
            it.want.last = 1'b1;
            it.want.status = trs_pkg::ST_EMPTY;
            wipe_record();
            return it;
         end
         total = 1 + rec_fields + rec_len;
         pos = rd_pos;
         if (pos >= total) pos = total - 1;
         if (pos == 0) it.want.data = rec_fields;
         else if (pos <= rec_fields) it.want.data = {4'h0, code_mem[pos - 1]};
         else it.want.data = byte_mem[pos - 1 - rec_fields];
         it.want.status = err_bits[1] ? trs_pkg::ST_OVERFLOW :
                          (err_bits[0] ? trs_pkg::ST_DROPPED : trs_pkg::ST_OK);
         if (pos + 1 >= total) begin
            it.want.last = 1'b1;
            wipe_record();
         end else begin
            rd_pos = 13'(pos + 1);
         end
         return it;
      end
      if (it.cmd == trs_pkg::CMD_BYTE) begin
         if (owed != 0) begin
            byte_mem[rec_len - owed] = it.cbyte;
            byte_set[rec_len - owed] = 1'b1;
            owed = owed - 13'd1;
         end
         return it;
      end
      if (it.cmd > trs_pkg::CMD_BYTE) return it;
      owed = '0;
      case (it.cmd)
         trs_pkg::CMD_NULL: begin
            if (has_room(0)) push_code(trs_pkg::CODE_NULL);
         end
         trs_pkg::CMD_INT: begin
            v = it.ival;
            if (v == 64'd0) begin
               code = trs_pkg::CODE_ZERO;
               nb = 0;
            end else if (v == 64'd1) begin
               code = trs_pkg::CODE_ONE;
               nb = 0;
            end else if (v == {{56{v[7]}}, v[7:0]}) begin
               code = trs_pkg::CODE_INT8;
               nb = 1;
            end else if (v == {{48{v[15]}}, v[15:0]}) begin
               code = trs_pkg::CODE_INT16;
               nb = 2;
            end else if (v == {{32{v[31]}}, v[31:0]}) begin
               code = trs_pkg::CODE_INT32;
               nb = 4;
            end else begin
               code = trs_pkg::CODE_INT64;
               nb = 8;
            end
            if (has_room(nb)) begin
               push_code(code);
               for (int k = nb - 1; k >= 0; k--) push_byte(v[8*k +: 8]);
            end
         end
         trs_pkg::CMD_FLOAT: begin
            if (has_room(8)) begin
               push_code(trs_pkg::CODE_FLOAT);
               for (int k = 0; k < 8; k++) push_byte(it.fbits[8*k +: 8]);
            end
         end
         default: begin
            code = (it.cmd == trs_pkg::CMD_TEXT) ? trs_pkg::CODE_TEXT : trs_pkg::CODE_BLOB;
            if (has_room(4 + it.clen)) begin
               push_code(code);
               push_byte(8'h00);
               push_byte(8'h00);
               push_byte({3'b000, it.clen[12:8]});
               push_byte(it.clen[7:0]);
               rec_len = rec_len + it.clen;
               owed = it.clen;
            end
         end
      endcase
      return it;
   endfunction

   function automatic field_req_type random_req();
      field_req_type r;
      r = '0;
      r.cmd   = 3'($urandom_range(7));
      r.ival  = {$urandom, $urandom};
      r.fbits = {$urandom, $urandom};
      r.clen  = 13'($urandom_range(8191));
      r.cbyte = 8'($urandom);
      r.rd    = 1'b0;
      return r;
   endfunction

   function automatic logic [63:0] shaped_int();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(5))
         0: v = 64'd0;
         1: v = 64'd1;
         2: v = {{56{v[7]}}, v[7:0]};
         3: v = {{48{v[15]}}, v[15:0]};
         4: v = {{32{v[31]}}, v[31:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic push_req(input field_req_type r);
      if (r.rd || r.cmd < trs_pkg::CMD_BYTE || (r.cmd == trs_pkg::CMD_BYTE && owed != 0)) begin
         stim_count++;
      end
      pending_reqs.push_back(serialize_step(r));
   endtask

   task automatic add_byte();
      field_req_type f;
      f = random_req();
      f.cmd = trs_pkg::CMD_BYTE;
      push_req(f);
   endtask

   // fill owed content first wherever a read or an abandon would expose unwritten memory
   task automatic queue_req(input field_req_type r);
      int total;
      int pos;
      bit gap;
      if (r.rd) begin
         forever begin
            if (rec_fields == 0 || owed == 0) break;
            total = 1 + rec_fields + rec_len;
            pos = (rd_pos >= total) ? total - 1 : rd_pos;
            if (pos <= rec_fields || byte_set[pos - 1 - rec_fields]) break;
            add_byte();
         end
      end else if (r.cmd < trs_pkg::CMD_BYTE) begin
         forever begin
            gap = 1'b0;
            for (int i = rec_len - owed; i < rec_len; i++) begin
               if (!byte_set[i]) gap = 1'b1;
            end
            if (!gap) break;
            add_byte();
         end
      end
      push_req(r);
   endtask

   task automatic read_one();
      field_req_type r;
      r = random_req();
      r.rd = 1'b1;
      queue_req(r);
   endtask

   task automatic read_out();
      do begin
         read_one();
      end while (!pending_reqs[pending_reqs.size() - 1].want.last);
   endtask

   task automatic add_content(input logic [2:0] cmd, input int len, input int nfill);
      field_req_type r;
      r = random_req();
      r.cmd = cmd;
      r.clen = 13'(len);
      queue_req(r);
      repeat (nfill) add_byte();
   endtask

   task automatic mixed_field();
      field_req_type r;
      int            pick;
      int            len;
      r = random_req();
      pick = $urandom_range(99);
      if (pick < 10) begin
         r.cmd = trs_pkg::CMD_NULL;
      end else if (pick < 45) begin
         r.cmd = trs_pkg::CMD_INT;
         r.ival = shaped_int();
      end else if (pick < 58) begin
         r.cmd = trs_pkg::CMD_FLOAT;
      end else if (pick < 82) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(7, 60) : $urandom_range(6);
         add_content(($urandom_range(1) != 0) ? trs_pkg::CMD_TEXT : trs_pkg::CMD_BLOB, len,
                     ($urandom_range(4) == 0) ? $urandom_range(len) : len);
         return;
      end else if (pick < 90) begin
         case ($urandom_range(2))
            0: r.cmd = CMD_SPARE6;
            1: r.cmd = CMD_SPARE7;
            default: r.cmd = trs_pkg::CMD_BYTE;
         endcase
      end else begin
         r.rd = 1'b1;
      end
      queue_req(r);
   endtask

   task automatic mixed_record();
      if ($urandom_range(7) == 0) read_one();
      repeat ($urandom_range(1, 10)) mixed_field();
      if ($urandom_range(9) == 0) begin
         add_content(($urandom_range(1) != 0) ? trs_pkg::CMD_TEXT : trs_pkg::CMD_BLOB,
                     $urandom_range(4093 - rec_len, 8191), $urandom_range(2));
      end
      read_out();
   endtask

   task automatic mixed_records(input int n);
      int start;
      start = stim_count;
      while (stim_count - start < n) mixed_record();
   endtask

   // run past the field limit, optionally overflow the payload before that, read the head
   task automatic full_record(input bit with_overflow);
      field_req_type r;
      for (int i = 0; i < MAX_FIELDS + 3; i++) begin
         if (with_overflow && i == 200) begin
            add_content(trs_pkg::CMD_BLOB, $urandom_range(4093, 8191), 1);
         end
         r = random_req();
         r.cmd = ($urandom_range(3) == 0) ? trs_pkg::CMD_NULL : trs_pkg::CMD_INT;
         r.ival = {{56{r.ival[7]}}, r.ival[7:0]};
         if ($urandom_range(2) == 0) r.ival = 64'($urandom_range(1));
         queue_req(r);
      end
      repeat (4) read_one();
   endtask

   task automatic directed_record();
      field_req_type r;
      logic [63:0]   corners [9];
      corners = '{64'd0, 64'd1, -64'sd128, 64'd127, 64'd128, -64'sd32769,
                  64'd2147483648, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};
      read_one();
      r = random_req();
      r.cmd = trs_pkg::CMD_NULL;
      queue_req(r);
      foreach (corners[k]) begin
         r = random_req();
         r.cmd = trs_pkg::CMD_INT;
         r.ival = corners[k];
         queue_req(r);
      end
      r = random_req();
      r.cmd = trs_pkg::CMD_FLOAT;
      r.fbits = '1;
      queue_req(r);
      r.fbits = 64'h0123_4567_89AB_CDEF;
      queue_req(r);
      add_content(trs_pkg::CMD_TEXT, 0, 0);
      add_content(trs_pkg::CMD_BLOB, 2, 2);
      r = random_req();
      r.cmd = trs_pkg::CMD_BYTE;
      queue_req(r);
      r.cmd = CMD_SPARE6;
      queue_req(r);
      r.cmd = CMD_SPARE7;
      queue_req(r);
      add_content(trs_pkg::CMD_BLOB, PAYLOAD_DEPTH, 1);
      add_content(trs_pkg::CMD_TEXT, 8191, 0);
      read_out();
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready && on_bus.has_rsp) expected_bytes.push_back(on_bus.want);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && !idle_roll()) begin
               on_bus = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, on_bus.cbyte, on_bus.clen, on_bus.fbits, on_bus.ival};
               req_tuser  <= {on_bus.rd, on_bus.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected item, byte", rsp_tdata, 8'h00);
            end else begin
               head_byte = expected_bytes.pop_front();
               if (rsp_tdata !== head_byte.data) begin
                  report_mismatch("byte", rsp_tdata, head_byte.data);
               end
               if (rsp_tlast !== head_byte.last) begin
                  report_mismatch("last", {7'b0, rsp_tlast}, {7'b0, head_byte.last});
               end
               if (rsp_tuser !== head_byte.status) begin
                  report_mismatch("status", {6'b0, rsp_tuser}, {6'b0, head_byte.status});
               end
            end
            checked_bytes++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (checked_bytes == 30 && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_roll();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      directed_record();
      mixed_records(50);
      full_record(1'b0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_tvalid || expected_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
